// ===== rtl/stoi_pkg.sv =====
// shared types, constants and helpers for the custom-base string to integer parser
`default_nettype none

package stoi_pkg;

  // field and register widths
  localparam int CHAR_W      = 8;
  localparam int VALUE_W     = 32;
  localparam int CFG_W       = 64;
  localparam int LEN_W       = 5;
  localparam int ALPHA_CHARS = 16;
  localparam int DIGIT_W     = $clog2(ALPHA_CHARS);
  localparam int CFG_IDX_W   = 2;

  // default radix limit
  localparam int MAX_BASE_DEF = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEN   = 2'd2;

  // register reset values: "0123456789", radix 10
  localparam logic [CFG_W-1:0] ALPHA_LOW_RST  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_W-1:0] ALPHA_HIGH_RST = 64'h0000_0000_0000_3938;
  localparam logic [LEN_W-1:0] BASE_LEN_RST   = 5'd10;

  // special characters
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;

  // parser phase, one-hot
  typedef enum logic [3:0] {
    PH_SPACE = 4'b0001,
    PH_SIGN  = 4'b0010,
    PH_DIGIT = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  // alphabet lookup result for one character
  typedef struct packed {
    logic               hit;
    logic [DIGIT_W-1:0] digit;
    logic               base_ok;
  } match_t;

  // space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_sign(input logic [CHAR_W-1:0] c);
    is_sign = (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/string_to_int_custom_base.sv =====
// top level: streaming signed integer parser over a configurable alphabet
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------
//   input   | in        | in_valid / in_ready   | char_in
//   output  | out       | out_valid / out_ready | value, base_ok
//   config  | in        | cfg_we                | cfg_index, cfg_data
//
// one character per cycle unless a zero byte waits; a character is held in the input register
// and consumed from there against the parser state, so a result is registered as its zero
// byte leaves the input register. the state update is one 32x5 multiply-add.
// reset (synchronous) restores the default alphabet and clears the parser.
// a zero byte waits in the input register while the result register is full.
`default_nettype none

module string_to_int_custom_base #(
  parameter int MAX_BASE = stoi_pkg::MAX_BASE_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [stoi_pkg::CHAR_W-1:0]      char_in,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [stoi_pkg::VALUE_W-1:0]   value,
  output logic                                  base_ok,
  input  wire logic                             cfg_we,
  input  wire logic [stoi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [stoi_pkg::CFG_W-1:0]       cfg_data
);

  // configuration registers
  logic [stoi_pkg::CFG_W-1:0]  alphabet_low;
  logic [stoi_pkg::CFG_W-1:0]  alphabet_high;
  logic [stoi_pkg::LEN_W-1:0]  base_length;

  // input register
  logic                        stage_valid;
  logic [stoi_pkg::CHAR_W-1:0] stage_char;

  // parser state
  stoi_pkg::phase_t             phase, phase_next;
  logic                         negative, negative_next;
  logic [stoi_pkg::VALUE_W-1:0] accumulator, accumulator_next;

  stoi_pkg::match_t             match;
  logic                         proc_fire;
  logic                         is_end;
  logic [stoi_pkg::VALUE_W-1:0] mac;
  logic [stoi_pkg::VALUE_W-1:0] signed_acc;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_low  <= stoi_pkg::ALPHA_LOW_RST;
      alphabet_high <= stoi_pkg::ALPHA_HIGH_RST;
      base_length   <= stoi_pkg::BASE_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stoi_pkg::CFG_ALPHA_LOW:  alphabet_low  <= cfg_data;
        stoi_pkg::CFG_ALPHA_HIGH: alphabet_high <= cfg_data;
        stoi_pkg::CFG_BASE_LEN:   base_length   <= cfg_data[stoi_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // alphabet lookup
  stoi_alpha #(
    .MAX_BASE (MAX_BASE)
  ) u_alpha (
    .alphabet_low  (alphabet_low),
    .alphabet_high (alphabet_high),
    .base_length   (base_length),
    .ch            (stage_char),
    .match         (match)
  );

  // handshake: only a zero byte needs room in the result register
  assign is_end    = (stage_char == stoi_pkg::CH_NUL);
  assign proc_fire = stage_valid && (!is_end || !out_valid || out_ready);
  assign in_ready  = !stage_valid || proc_fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_char <= char_in;
    end
  end

  // multiply-add for the next digit
  assign mac = stoi_pkg::VALUE_W'(accumulator * stoi_pkg::VALUE_W'(base_length)) +
               stoi_pkg::VALUE_W'(match.digit);

  // parser next state
  always_comb begin
    phase_next       = phase;
    negative_next    = negative;
    accumulator_next = accumulator;
    if (is_end) begin
      phase_next       = stoi_pkg::PH_SPACE;
      negative_next    = 1'b0;
      accumulator_next = '0;
    end else begin
      unique case (phase) inside
        stoi_pkg::PH_SPACE, stoi_pkg::PH_SIGN: begin
          if ((phase == stoi_pkg::PH_SPACE) && stoi_pkg::is_space(stage_char)) begin
            phase_next = stoi_pkg::PH_SPACE;
          end else if (stoi_pkg::is_sign(stage_char)) begin
            phase_next    = stoi_pkg::PH_SIGN;
            negative_next = negative ^ (stage_char == stoi_pkg::CH_MINUS);
          end else if (match.hit) begin
            phase_next       = stoi_pkg::PH_DIGIT;
            accumulator_next = mac;
          end else begin
            phase_next = stoi_pkg::PH_DONE;
          end
        end
        stoi_pkg::PH_DIGIT: begin
          if (match.hit) begin
            accumulator_next = mac;
          end else begin
            phase_next = stoi_pkg::PH_DONE;
          end
        end
        stoi_pkg::PH_DONE: phase_next = stoi_pkg::PH_DONE;
        default: phase_next = stoi_pkg::PH_SPACE;
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= stoi_pkg::PH_SPACE;
      negative    <= 1'b0;
      accumulator <= '0;
    end else if (proc_fire) begin
      phase       <= phase_next;
      negative    <= negative_next;
      accumulator <= accumulator_next;
    end
  end

  // sign applied at the end of the string
  assign signed_acc = negative ? (stoi_pkg::VALUE_W'(0) - accumulator) : accumulator;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire && is_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && is_end) begin
      value   <= match.base_ok ? signed_acc : '0;
      base_ok <= match.base_ok;
    end
  end

  // a zero byte leaves the parser in its reset state
  assert property (@(posedge clk) disable iff (rst)
    proc_fire && is_end |=> (phase == stoi_pkg::PH_SPACE) && !negative && (accumulator == '0))
    else $error("parser not cleared after end of string");

  // nothing is gathered while whitespace is skipped
  assert property (@(posedge clk) disable iff (rst)
    (phase == stoi_pkg::PH_SPACE) |-> !negative && (accumulator == '0))
    else $error("state gathered during whitespace skip");

  // an invalid base always reports zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !base_ok |-> (value == '0))
    else $error("nonzero value with invalid base");

  // a new character only enters when the held one moves on
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !stage_valid || proc_fire)
    else $error("input register overwritten");

  // a valid base has a radix within range
  assert property (@(posedge clk) disable iff (rst)
    match.base_ok |-> (base_length >= stoi_pkg::LEN_W'(2)) &&
                      (base_length <= stoi_pkg::LEN_W'(MAX_BASE)))
    else $error("base reported valid with radix out of range");

endmodule

`default_nettype wire

// ===== rtl/stoi_alpha.sv =====
// alphabet digit lookup and base validity check
`default_nettype none

module stoi_alpha #(
  parameter int MAX_BASE = stoi_pkg::MAX_BASE_DEF
) (
  input  wire logic [stoi_pkg::CFG_W-1:0]  alphabet_low,
  input  wire logic [stoi_pkg::CFG_W-1:0]  alphabet_high,
  input  wire logic [stoi_pkg::LEN_W-1:0]  base_length,
  input  wire logic [stoi_pkg::CHAR_W-1:0] ch,
  output stoi_pkg::match_t                 match
);

  localparam int NCHARS = stoi_pkg::ALPHA_CHARS;
  localparam int PER_WORD = stoi_pkg::CFG_W / stoi_pkg::CHAR_W;
  localparam logic [stoi_pkg::LEN_W-1:0] MAX_LEN = stoi_pkg::LEN_W'(MAX_BASE);

  logic [stoi_pkg::CHAR_W-1:0] chars [NCHARS];
  logic [stoi_pkg::LEN_W-1:0]  used_len;
  logic                        alpha_ok;

  // unpack alphabet words into characters
  always_comb begin
    for (int i = 0; i < PER_WORD; i++) begin
      chars[i]            = alphabet_low[i*stoi_pkg::CHAR_W +: stoi_pkg::CHAR_W];
      chars[i + PER_WORD] = alphabet_high[i*stoi_pkg::CHAR_W +: stoi_pkg::CHAR_W];
    end
  end

  // characters in use
  assign used_len = (base_length > MAX_LEN) ? MAX_LEN : base_length;

  // first alphabet position equal to the character
  always_comb begin
    match.hit     = 1'b0;
    match.digit   = '0;
    match.base_ok = alpha_ok;
    for (int i = MAX_BASE - 1; i >= 0; i--) begin
      if ((stoi_pkg::LEN_W'(i) < used_len) && (chars[i] == ch)) begin
        match.hit   = 1'b1;
        match.digit = stoi_pkg::DIGIT_W'(i);
      end
    end
  end

  // validity: radix in range, no bad character, no duplicate
  always_comb begin
    logic bad;
    bad = 1'b0;
    for (int i = 0; i < MAX_BASE; i++) begin
      if (stoi_pkg::LEN_W'(i) < used_len) begin
        if ((chars[i] == stoi_pkg::CH_NUL) || stoi_pkg::is_sign(chars[i]) ||
            stoi_pkg::is_space(chars[i])) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < MAX_BASE; j++) begin
          if ((stoi_pkg::LEN_W'(j) < used_len) && (chars[j] == chars[i])) begin
            bad = 1'b1;
          end
        end
      end
    end
    alpha_ok = !bad && (base_length >= stoi_pkg::LEN_W'(2)) && (base_length <= MAX_LEN);
  end

endmodule

`default_nettype wire
